// File: src/jmbd_pkg.sv
// Package for the Japanese multibyte input decoder.
// Holds encoding codes, lead byte constants and the decode result type.
// No dependencies.
package jmbd_pkg;

  localparam logic ENC_EUC  = 1'b0;
  localparam logic ENC_SJIS = 1'b1;

  localparam logic [7:0] LEAD_NONE = 8'h00;
  localparam logic [7:0] LEAD_SS2  = 8'h8E;
  localparam logic [7:0] LEAD_SS3  = 8'h8F;

  localparam logic [7:0] SJIS_CTRL_MAX = 8'h20;
  localparam logic [7:0] SJIS_HIGH_LEAD = 8'hE0;
  localparam logic [7:0] SJIS_HIGH_ADJ  = 8'h40;
  localparam logic [7:0] SJIS_TRAIL_EVEN = 8'h9F;
  localparam logic [7:0] SJIS_TRAIL_GAP  = 8'h7F;
  // (2*L + 0xB0 - 0x110) and (2*L + 0xB1 - 0x112), modulo 256
  localparam logic [7:0] SJIS_HI_EVEN_OFS = 8'hA0;
  localparam logic [7:0] SJIS_HI_ODD_OFS  = 8'h9F;
  localparam logic [8:0] SJIS_LO_EVEN_OFS = 9'h002;
  localparam logic [8:0] SJIS_LO_ODD_OFS  = 9'h061;

  localparam logic [7:0] KANA_EUC_HI  = 8'h01;
  localparam logic [7:0] KANA_SJIS_HI = 8'h01;

  typedef struct packed {
    logic        emit;
    logic [15:0] code;
    logic [7:0]  lead_next;
  } jmbd_dec_t;

endpackage

// File: src/jmbd_ifs.sv
// Valid/ready channel interfaces for the Japanese multibyte input decoder.
// Byte input, character output and encoding configuration. No dependencies.
interface jmbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface jmbd_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface jmbd_cfg_if;
  logic valid;
  logic ready;
  logic input_encoding;
  modport source (output valid, output input_encoding, input ready);
  modport sink (input valid, input input_encoding, output ready);
endinterface

// File: src/jmbd_decode.sv
// Combinational byte decoder: one byte plus the pending lead gives an
// optional character and the next lead. Depends on jmbd_pkg.
module jmbd_decode (
  input  logic              mode,
  input  logic [7:0]        lead,
  input  logic [7:0]        in_byte,
  output jmbd_pkg::jmbd_dec_t dec
);

  logic [7:0] sj_hi_base;
  logic [7:0] sj_trail;
  logic [7:0] sj_hi;
  logic [8:0] sj_lo;

  // Shift_JIS pair to JIS row/cell
  always_comb begin
    sj_hi_base = (lead >= jmbd_pkg::SJIS_HIGH_LEAD) ? lead - jmbd_pkg::SJIS_HIGH_ADJ : lead;
    if (in_byte >= jmbd_pkg::SJIS_TRAIL_EVEN) begin
      sj_trail = in_byte;
      sj_hi    = {sj_hi_base[6:0], 1'b0} + jmbd_pkg::SJIS_HI_EVEN_OFS;
      sj_lo    = {1'b0, sj_trail} + jmbd_pkg::SJIS_LO_EVEN_OFS;
    end else begin
      sj_trail = (in_byte >= jmbd_pkg::SJIS_TRAIL_GAP) ? in_byte - 8'd1 : in_byte;
      sj_hi    = {sj_hi_base[6:0], 1'b0} + jmbd_pkg::SJIS_HI_ODD_OFS;
      sj_lo    = {1'b0, sj_trail} + jmbd_pkg::SJIS_LO_ODD_OFS;
    end
  end

  always_comb begin
    dec.emit      = 1'b0;
    dec.code      = {8'h00, in_byte};
    dec.lead_next = jmbd_pkg::LEAD_NONE;
    if (mode == jmbd_pkg::ENC_SJIS) begin
      if (in_byte > jmbd_pkg::SJIS_CTRL_MAX && lead != jmbd_pkg::LEAD_NONE) begin
        dec.emit = 1'b1;
        // carry out of the trail lands in bit 8
        dec.code = {1'b0, sj_hi[6:1], sj_hi[0] | sj_lo[8], 1'b0, sj_lo[6:0]};
      end else begin
        case (in_byte) inside
          [8'h00:8'h7F]: dec.emit = 1'b1;
          [8'hA0:8'hDF]: begin
            dec.emit = 1'b1;
            dec.code = {jmbd_pkg::KANA_SJIS_HI, in_byte};
          end
          default: dec.lead_next = in_byte;
        endcase
      end
    end else begin
      if (!in_byte[7]) begin
        dec.emit = 1'b1;
      end else if (lead == jmbd_pkg::LEAD_SS3) begin
        dec.lead_next = in_byte;
      end else if (lead == jmbd_pkg::LEAD_SS2) begin
        dec.emit = 1'b1;
        dec.code = {jmbd_pkg::KANA_EUC_HI, in_byte};
      end else if (lead != jmbd_pkg::LEAD_NONE) begin
        dec.emit = 1'b1;
        dec.code = {lead, 1'b0, in_byte[6:0]};
      end else begin
        case (in_byte) inside
          jmbd_pkg::LEAD_SS2, jmbd_pkg::LEAD_SS3: dec.lead_next = in_byte;
          default: dec.lead_next = {1'b0, in_byte[6:0]};
        endcase
      end
    end
  end

endmodule

// File: src/japanese_multibyte_input_decoder.sv
// Top level of the Japanese multibyte input decoder.
// Depends on jmbd_pkg, jmbd_ifs and jmbd_decode.

// Decodes a raw EUC-JP or Shift_JIS byte stream into 16-bit character codes,
// one byte per clock unless the output stalls. A byte is registered on entry,
// then decoded against the pending lead byte and written to the output
// register once that register is free; lead bytes produce no beat.
// Throughput is one byte per cycle while char_out is ready. Write the encoding
// only while idle; the write also drops any pending lead byte.
module japanese_multibyte_input_decoder (
  input  logic               clk,
  input  logic               rst,
  jmbd_byte_if.sink          byte_in,
  jmbd_char_if.source        char_out,
  jmbd_cfg_if.sink           cfg
);

  logic        mode;
  logic [7:0]  lead;
  logic        in_valid;
  logic [7:0]  in_data;
  logic        out_valid;
  logic [15:0] out_code;
  logic        advance;
  jmbd_pkg::jmbd_dec_t dec;

  jmbd_decode u_decode (
    .mode    (mode),
    .lead    (lead),
    .in_byte (in_data),
    .dec     (dec)
  );

  assign advance            = in_valid && (!out_valid || char_out.ready);
  assign byte_in.ready      = !in_valid || advance;
  assign cfg.ready          = 1'b1;
  assign char_out.valid     = out_valid;
  assign char_out.char_code = out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= jmbd_pkg::ENC_EUC;
      lead      <= jmbd_pkg::LEAD_NONE;
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (byte_in.ready) begin
        in_valid <= byte_in.valid;
      end
      if (advance) begin
        if (dec.emit) begin
          out_valid <= 1'b1;
        end else if (char_out.ready) begin
          out_valid <= 1'b0;
        end
      end else if (char_out.ready) begin
        out_valid <= 1'b0;
      end
      // configuration wins over a lead update
      if (cfg.valid && cfg.ready) begin
        mode <= cfg.input_encoding;
        lead <= jmbd_pkg::LEAD_NONE;
      end else if (advance) begin
        lead <= dec.lead_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_data <= byte_in.in_byte;
    end
    if (advance && dec.emit) begin
      out_code <= dec.code;
    end
  end

  a_cfg_clears_lead: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready |=> lead == jmbd_pkg::LEAD_NONE)
    else $error("lead not cleared by encoding write");

  a_sjis_lead_high: assert property (@(posedge clk) disable iff (rst)
    mode == jmbd_pkg::ENC_SJIS |-> lead == jmbd_pkg::LEAD_NONE || lead[7])
    else $error("Shift_JIS lead byte without bit 7");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    advance && dec.emit |=> out_valid && out_code == $past(dec.code))
    else $error("decoded character not presented");

  a_stall_has_byte: assert property (@(posedge clk) disable iff (rst)
    !byte_in.ready |-> in_valid && out_valid && !char_out.ready)
    else $error("input stalled without a held byte");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for japanese_multibyte_input_decoder: EUC-JP and Shift_JIS byte streams
// are checked against a character predictor held in a small scoreboard class.
// Depends on jmbd_pkg, the jmbd channel interfaces and the decoder RTL.
module testbench;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned TAIL_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_BYTES = 210;

  typedef enum int {
    SEQ_ASCII, SEQ_KANA, SEQ_DOUBLE, SEQ_TRIPLE, SEQ_BROKEN, SEQ_NOISE
  } seq_kind_t;

  class char_scoreboard;
    logic        encoding;
    logic [7:0]  lead_byte;
    logic [15:0] char_q[$];
    int unsigned err_cnt;

    function new();
      encoding  = jmbd_pkg::ENC_EUC;
      lead_byte = jmbd_pkg::LEAD_NONE;
      err_cnt   = 0;
    endfunction

    function void set_encoding(logic e);
      encoding  = e;
      lead_byte = jmbd_pkg::LEAD_NONE;
    endfunction

    // Advance the lead byte; return 1 when the byte completes a character.
    function bit predict_char(input logic [7:0] b, output logic [15:0] word);
      logic [31:0] hi;
      logic [31:0] lo;
      word = 16'h0000;
      if (encoding == jmbd_pkg::ENC_EUC) begin
        if (b <= 8'h7F) begin
          lead_byte = jmbd_pkg::LEAD_NONE;
          word = {8'h00, b};
          return 1'b1;
        end
        if (lead_byte != jmbd_pkg::LEAD_NONE) begin
          if (lead_byte == jmbd_pkg::LEAD_SS3) begin
            lead_byte = b | 8'h80;
            return 1'b0;
          end
          if (lead_byte == jmbd_pkg::LEAD_SS2)
            word = 16'h0180 | {8'h00, b};
          else
            word = {lead_byte, 1'b0, b[6:0]};
          lead_byte = jmbd_pkg::LEAD_NONE;
          return 1'b1;
        end
        lead_byte = (b == jmbd_pkg::LEAD_SS2 || b == jmbd_pkg::LEAD_SS3) ?
                    b : {1'b0, b[6:0]};
        return 1'b0;
      end
      if (b > 8'h20 && lead_byte != jmbd_pkg::LEAD_NONE) begin
        hi = {24'h0, lead_byte};
        lo = {24'h0, b};
        if (hi >= 32'hE0)
          hi = hi - 32'h40;
        if (lo >= 32'h9F) begin
          hi = hi + hi + 32'hB0 - 32'h110;
          lo = lo + 32'h02;
        end else begin
          if (lo >= 32'h7F)
            lo = lo - 32'h01;
          hi = hi + hi + 32'hB1 - 32'h112;
          lo = lo + 32'h61;
        end
        word = 16'(((hi << 8) | lo) & 32'h7F7F);
        lead_byte = jmbd_pkg::LEAD_NONE;
        return 1'b1;
      end
      if (b <= 8'h7F) begin
        lead_byte = jmbd_pkg::LEAD_NONE;
        word = {8'h00, b};
        return 1'b1;
      end
      if (b >= 8'hA0 && b < 8'hE0) begin
        lead_byte = jmbd_pkg::LEAD_NONE;
        word = 16'h0100 | {8'h00, b};
        return 1'b1;
      end
      lead_byte = b;
      return 1'b0;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [15:0] word;
      if (predict_char(b, word))
        char_q.push_back(word);
    endfunction

    function void check_char(logic [15:0] got);
      logic [15:0] want;
      if (char_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("char_code beat %h with nothing expected", got);
        return;
      end
      want = char_q.pop_front();
      if (got !== want) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("char_code mismatch: expected %h got %h", want, got);
      end
    endfunction

    function int unsigned outstanding();
      return char_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hold_req;
  bit   no_gaps;
  logic cur_enc;
  int unsigned cycle_cnt;
  logic [7:0] byte_burst[$];
  char_scoreboard sb;

  jmbd_byte_if byte_if ();
  jmbd_char_if char_if ();
  jmbd_cfg_if  cfg_if ();

  japanese_multibyte_input_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_if),
    .char_out (char_if),
    .cfg      (cfg_if)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Byte, config and character monitors, sampled at the edge.
  always @(posedge clk) begin
    if (!rst && byte_if.valid && byte_if.ready)
      sb.note_byte(byte_if.in_byte);
  end

  always @(posedge clk) begin
    if (!rst && cfg_if.valid && cfg_if.ready)
      sb.set_encoding(cfg_if.input_encoding);
  end

  always @(posedge clk) begin
    if (!rst && char_if.valid && char_if.ready)
      sb.check_char(char_if.char_code);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Receiver: random stretches of ready and stall, plus one long hold-off on request.
  initial begin
    int unsigned r;
    int unsigned len;
    char_if.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req <= 1'b0;
        char_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          char_if.ready <= 1'b1;
          len = $urandom_range(1, 8);
        end else if (r < 60) begin
          char_if.ready <= 1'b1;
          len = $urandom_range(40, 120);
        end else if (r < 95) begin
          char_if.ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          char_if.ready <= 1'b0;
          len = $urandom_range(10, 40);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_burst();
    logic [7:0]  b;
    int unsigned gap;
    while (byte_burst.size() != 0) begin
      b = byte_burst.pop_front();
      byte_if.valid   <= 1'b1;
      byte_if.in_byte <= b;
      @(posedge clk);
      while (!byte_if.ready) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every expected character has come, then let the pipe empty.
  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_encoding(input logic e);
    wait_drained();
    cfg_if.valid          <= 1'b1;
    cfg_if.input_encoding <= e;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    cur_enc = e;
  endtask

  function automatic seq_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return SEQ_ASCII;
    if (r < 40) return SEQ_KANA;
    if (r < 65) return SEQ_DOUBLE;
    if (r < 80) return SEQ_TRIPLE;
    if (r < 90) return SEQ_BROKEN;
    return SEQ_NOISE;
  endfunction

  function automatic logic [7:0] sjis_lead();
    if ($urandom_range(0, 1) == 0)
      return 8'($urandom_range(8'h80, 8'h9F));
    return 8'($urandom_range(8'hE0, 8'hFF));
  endfunction

  function automatic void build_sequence(logic e);
    seq_kind_t   kind;
    logic [7:0]  lead;
    int unsigned n;
    kind = pick_kind();
    if (kind == SEQ_NOISE) begin
      n = $urandom_range(1, 4);
      repeat (n) byte_burst.push_back(8'($urandom_range(0, 255)));
    end else if (e == jmbd_pkg::ENC_EUC) begin
      case (kind)
        SEQ_ASCII: byte_burst.push_back(8'($urandom_range(0, 8'h7F)));
        SEQ_KANA: begin
          byte_burst.push_back(jmbd_pkg::LEAD_SS2);
          byte_burst.push_back(8'($urandom_range(8'h80, 8'hFF)));
        end
        SEQ_DOUBLE: begin
          lead = 8'($urandom_range(8'h80, 8'hFF));
          if (lead == jmbd_pkg::LEAD_SS2 || lead == jmbd_pkg::LEAD_SS3)
            lead = 8'hA1;
          byte_burst.push_back(lead);
          byte_burst.push_back(8'($urandom_range(8'h80, 8'hFF)));
        end
        SEQ_TRIPLE: begin
          byte_burst.push_back(jmbd_pkg::LEAD_SS3);
          byte_burst.push_back(8'($urandom_range(8'h80, 8'hFF)));
          byte_burst.push_back(8'($urandom_range(8'h80, 8'hFF)));
        end
        default: begin
          byte_burst.push_back(8'($urandom_range(8'h80, 8'hFF)));
          byte_burst.push_back(8'($urandom_range(0, 8'h7F)));
        end
      endcase
    end else begin
      case (kind)
        SEQ_ASCII: byte_burst.push_back(8'($urandom_range(0, 8'h7F)));
        SEQ_KANA: byte_burst.push_back(8'($urandom_range(8'hA0, 8'hDF)));
        SEQ_DOUBLE, SEQ_TRIPLE: begin
          byte_burst.push_back(sjis_lead());
          byte_burst.push_back(8'($urandom_range(8'h21, 8'hFF)));
        end
        default: begin
          byte_burst.push_back(sjis_lead());
          byte_burst.push_back(8'($urandom_range(0, 8'h20)));
        end
      endcase
    end
  endfunction

  task automatic run_random(input bit with_hold, input bit with_pause);
    int unsigned sent;
    bit          held;
    bit          paused;
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    no_gaps = 1'b0;
    while (sent < PHASE_BYTES) begin
      if ($urandom_range(0, 29) == 0)
        no_gaps = !no_gaps;
      build_sequence(cur_enc);
      sent += byte_burst.size();
      send_burst();
      if (with_hold && !held && sent >= PHASE_BYTES / 3) begin
        hold_req <= 1'b1;
        held = 1'b1;
      end
      if (with_pause && !paused && sent >= PHASE_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    // Leave a lead byte pending now and then so the next write must drop it.
    if ($urandom_range(0, 1) == 1) begin
      if (cur_enc == jmbd_pkg::ENC_EUC)
        byte_burst.push_back(8'($urandom_range(8'h81, 8'hFF)));
      else
        byte_burst.push_back(sjis_lead());
      send_burst();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    sb                    = new();
    rst                   = 1'b1;
    hold_req              = 1'b0;
    no_gaps               = 1'b0;
    cur_enc               = jmbd_pkg::ENC_EUC;
    cycle_cnt             = 0;
    byte_if.valid         = 1'b0;
    byte_if.in_byte       = 8'h00;
    cfg_if.valid          = 1'b0;
    cfg_if.input_encoding = jmbd_pkg::ENC_EUC;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // EUC-JP: ASCII extremes, lead then ASCII, kana, JIS0208, JIS0212,
    // lead 0x80 as no lead, SS2 as middle byte of a JIS0212 sequence.
    byte_burst = '{8'h00, 8'hB0, 8'h7F, 8'h8E, 8'hA1, 8'hFE, 8'hFE,
                   8'h8F, 8'hA2, 8'hAF, 8'h80, 8'hC1, 8'hA1,
                   8'h8F, 8'h8E, 8'hA5};
    send_burst();

    // Shift_JIS: pair extremes, high leads, trail gap at 0x7F, dropped lead
    // before a control byte, single-byte kana edges.
    write_encoding(jmbd_pkg::ENC_SJIS);
    byte_burst = '{8'h81, 8'h40, 8'h9F, 8'hFC, 8'hE0, 8'h9F, 8'hFC, 8'h7E,
                   8'h81, 8'h7F, 8'h81, 8'h20, 8'hA0, 8'hDF};
    send_burst();

    write_encoding(jmbd_pkg::ENC_EUC);
    run_random(1'b0, 1'b0);
    write_encoding(jmbd_pkg::ENC_SJIS);
    run_random(1'b1, 1'b0);
    write_encoding(jmbd_pkg::ENC_SJIS);
    run_random(1'b0, 1'b1);
    write_encoding(jmbd_pkg::ENC_EUC);
    run_random(1'b1, 1'b1);
    write_encoding(jmbd_pkg::ENC_SJIS);
    run_random(1'b0, 1'b0);

    wait_drained();
    if (sb.err_cnt == 0 && sb.outstanding() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end
endmodule
